// ===== rtl/signed_int_to_decimal_ascii_top_macros.svh =====
// Assertion macros shared by the checker of the decimal text converter.
// No dependencies; include by bare file name.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SIDA_ASSERT_NOW(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SIDA_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies.
package sida_pkg;

  localparam int INT_WIDTH  = 32;
  // decimal digits needed for 2**INT_WIDTH - 1 (log10(2) ~ 0.30103)
  localparam int NUM_DIGITS = (INT_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(INT_WIDTH + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_NUL   = 8'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT,
    ST_TERM
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_MINUS,
    EMIT_DIGIT,
    EMIT_TERM
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  convert;
    logic  shift_digit;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic neg;
    logic top_zero;
  } ctrl_sts_t;

endpackage

// ===== rtl/sida_ctrl.sv =====
// Sequencer of the decimal text converter: conversion steps, leading-zero skip, emission.
// Depends on sida_pkg.
module sida_ctrl
  import sida_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd,
  input  ctrl_sts_t sts
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CONV;
          cnt_nxt   = CNT_W'(INT_WIDTH - 1);
        end
      end
      ST_CONV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_SKIP;
          cnt_nxt   = CNT_W'(NUM_DIGITS);
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if (sts.top_zero && cnt_r > CNT_W'(1)) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = sts.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '{load: 1'b0, convert: 1'b0, shift_digit: 1'b0, emit: EMIT_NONE};
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV: begin
        cmd.convert = 1'b1;
      end
      ST_SKIP: begin
        cmd.shift_digit = sts.top_zero && cnt_r > CNT_W'(1);
      end
      ST_SIGN: begin
        cmd.emit = EMIT_MINUS;
      end
      ST_DIGIT: begin
        cmd.emit        = EMIT_DIGIT;
        cmd.shift_digit = 1'b1;
      end
      ST_TERM: begin
        cmd.emit = EMIT_TERM;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/sida_dpath.sv =====
// Datapath of the decimal text converter: magnitude, shift-and-add-3 BCD register,
// output byte register. Depends on sida_pkg.
module sida_dpath
  import sida_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic signed [INT_WIDTH-1:0] in_value,
  input  ctrl_cmd_t                   cmd,
  output ctrl_sts_t                   sts,
  output logic                        out_strobe,
  output logic [7:0]                  out_character,
  output logic                        out_last
);

  logic [INT_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [BCD_W-1:0]     bcd_adj;
  logic                 neg_r, neg_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [7:0]           char_r, char_nxt;
  logic                 last_r, last_nxt;
  logic [3:0]           top_digit;
  logic [INT_WIDTH-1:0] raw;

  assign raw       = in_value;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      neg_nxt = raw[INT_WIDTH-1];
      bin_nxt = raw[INT_WIDTH-1] ? (~raw + INT_WIDTH'(1)) : raw;
      bcd_nxt = '0;
    end else if (cmd.convert) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[INT_WIDTH-1]};
      bin_nxt = {bin_r[INT_WIDTH-2:0], 1'b0};
    end else if (cmd.shift_digit) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'b0000};
    end
  end

  always_comb begin
    strobe_nxt = 1'b1;
    char_nxt   = ASCII_NUL;
    last_nxt   = 1'b0;
    case (cmd.emit)
      EMIT_NONE:  strobe_nxt = 1'b0;
      EMIT_MINUS: char_nxt   = ASCII_MINUS;
      EMIT_DIGIT: char_nxt   = ASCII_ZERO + {4'b0000, top_digit};
      EMIT_TERM:  last_nxt   = 1'b1;
      default:    strobe_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign sts.neg      = neg_r;
  assign sts.top_zero = (top_digit == 4'd0);

  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// Channel   Ports                                   Handshake
// request   in_value                                start & !busy
// result    out_character, out_last                 out_strobe, one cycle each
//
// A request is converted by a bit-serial shift-and-add-3 loop, one bit per cycle,
// then leading zero digits are dropped one per cycle and the text leaves one byte
// per cycle; busy stays high until the terminator is emitted, so a new request is
// not taken before the digits of the last one have all left.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops the strobe.
// Results cannot be stalled; the terminator shows in the cycle busy falls.
// Depends on sida_pkg, sida_ctrl, sida_dpath.
module signed_int_to_decimal_ascii_top
  import sida_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [INT_WIDTH-1:0] in_value,
  output logic                        out_strobe,
  output logic [7:0]                  out_character,
  output logic                        out_last
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sida_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  sida_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

// ===== rtl/sida_checker.sv =====
// Port-level checks for the decimal text converter, bound to its top level.
// Depends on sida_pkg and signed_int_to_decimal_ascii_top_macros.svh.
`include "signed_int_to_decimal_ascii_top_macros.svh"

module sida_checker
  import sida_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [7:0] out_character,
  input logic       out_last
);

  logic term_ok;
  logic text_byte_ok;

  assign term_ok      = (out_character == ASCII_NUL) && !busy;
  assign text_byte_ok = (out_character == ASCII_MINUS) ||
                        (out_character >= ASCII_ZERO && out_character <= ASCII_ZERO + 8'd9);

  `SIDA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_strobe)
  `SIDA_ASSERT_NOW(a_term_nul, clk, rst_n, out_strobe && out_last, term_ok)
  `SIDA_ASSERT_NOW(a_text_byte, clk, rst_n, out_strobe && !out_last, text_byte_ok)
  `SIDA_ASSERT_NEXT(a_minus_first, clk, rst_n, out_strobe && out_character == ASCII_MINUS, out_strobe && out_character != ASCII_MINUS && !out_last)

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_sida_checker (.*);

// ===== dv/signed_int_to_decimal_ascii_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the signed integer to decimal text converter.
// Drives numbers through the start/busy port and checks every text byte.
// Depends on sida_pkg and signed_int_to_decimal_ascii_top.
module signed_int_to_decimal_ascii_top_test;
  import sida_pkg::*;

  localparam int DEC_RADIX      = 10;
  localparam int RANDOM_NUMBERS = 420;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int TAIL_CYCLES    = 60;

  typedef struct {
    logic signed [INT_WIDTH-1:0] value;
    int unsigned                 gap_cycles;
    bit                          wait_drain;
  } number_req_t;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic signed [INT_WIDTH-1:0] in_value = '0;
  logic                        out_strobe;
  logic [7:0]                  out_character;
  logic                        out_last;

  number_req_t number_q [$];
  text_char_t  text_q [$];
  text_char_t  want;

  int total_numbers;
  int accepted_count;
  int neg_count;
  int zero_count;
  int ten_digit_count;
  int char_count;
  int fail_count;
  int cycle_count;
  int idle_cnt;

  signed_int_to_decimal_ascii_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // Expected text of one number: optional minus, digits MSB first, terminator.
  function automatic void push_decimal_text(logic signed [INT_WIDTH-1:0] value);
    logic [INT_WIDTH-1:0] mag;
    logic [7:0]           digits [$];
    text_char_t           tc;
    mag = value[INT_WIDTH-1] ? (~value + 1'b1) : value;
    do begin
      digits.push_front(ASCII_ZERO + 8'(mag % DEC_RADIX));
      mag = mag / DEC_RADIX;
    end while (mag != 0);
    if (value[INT_WIDTH-1]) begin
      tc.character = ASCII_MINUS;
      tc.last      = 1'b0;
      text_q.push_back(tc);
    end
    foreach (digits[i]) begin
      tc.character = digits[i];
      tc.last      = 1'b0;
      text_q.push_back(tc);
    end
    tc.character = ASCII_NUL;
    tc.last      = 1'b1;
    text_q.push_back(tc);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 5);
    return $urandom_range(20, 70);
  endfunction

  // Mix of raw words, numbers of a chosen digit count, values at and next to powers of ten, and extremes.
  function automatic logic signed [INT_WIDTH-1:0] pick_value();
    int unsigned                 sel;
    int unsigned                 ndig;
    longint                      p;
    longint                      lo;
    longint                      hi;
    longint                      mag;
    logic signed [INT_WIDTH-1:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      v = $urandom();
    end else if (sel < 85) begin
      ndig = $urandom_range(1, 10);
      p = 1;
      repeat (ndig - 1) p = p * DEC_RADIX;
      lo = (ndig == 1) ? 0 : p;
      hi = p * DEC_RADIX - 1;
      if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      mag = lo + $urandom_range(0, int'(hi - lo));
      v = INT_WIDTH'(mag);
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (sel < 95) begin
      p = 1;
      repeat ($urandom_range(0, 9)) p = p * DEC_RADIX;
      mag = p + $urandom_range(0, 2) - 1;
      v = INT_WIDTH'(mag);
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      case ($urandom_range(0, 4))
        0: v = 32'sh7FFF_FFFF;
        1: v = 32'sh8000_0000;
        2: v = 32'sh8000_0001;
        3: v = '0;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  function automatic void add_number(logic signed [INT_WIDTH-1:0] value, bit drain);
    number_req_t req;
    req.value      = value;
    req.gap_cycles = pick_gap();
    req.wait_drain = drain;
    number_q.push_back(req);
    total_numbers++;
  endfunction

  // Driver: take a request on start & !busy, then present the next one after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      idle_cnt = 0;
    end else begin
      if (start && !busy) begin
        push_decimal_text(in_value);
        accepted_count++;
        if (in_value < 0) neg_count++;
        if (in_value == 0) zero_count++;
        if (in_value >= 1000000000 || in_value <= -1000000000) ten_digit_count++;
      end
      if (!start || !busy) begin
        if (number_q.size() != 0 && idle_cnt >= number_q[0].gap_cycles &&
            (!number_q[0].wait_drain || text_q.size() == 0)) begin
          in_value <= number_q[0].value;
          start    <= 1'b1;
          void'(number_q.pop_front());
          idle_cnt = 0;
        end else begin
          start    <= 1'b0;
          idle_cnt++;
        end
      end
    end
  end

  // Monitor: every strobed byte must match the oldest expected byte.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual character %0d last %0b",
                 $time, out_character, out_last);
        fail_count++;
      end else begin
        want = text_q.pop_front();
        char_count++;
        if (out_character !== want.character) begin
          $display("%0t: character mismatch: expected %0d, actual %0d",
                   $time, want.character, out_character);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d numbers taken, %0d bytes pending",
               cycle_count, accepted_count, total_numbers, text_q.size());
      $display("signed_int_to_decimal_ascii_top regression: fail");
      $finish;
    end
  end

  initial begin
    int corner_vals [20];
    corner_vals = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
                    999999999, 1000000000, -1000000000, 1999999999, 2000000000,
                    123456789, -987654321};
    foreach (corner_vals[i]) add_number(corner_vals[i], i == 10);
    // Every so often hold the next request until all text has drained.
    for (int i = 0; i < RANDOM_NUMBERS; i++) add_number(pick_value(), (i % 70) == 35);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_numbers || text_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d numbers (%0d negative, %0d zero, %0d of ten digits)",
             accepted_count, neg_count, zero_count, ten_digit_count);
    $display("checked %0d text bytes, %0d errors", char_count, fail_count);
    if (fail_count == 0) begin
      $display("signed_int_to_decimal_ascii_top regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii_top regression: fail");
    end
    $finish;
  end

endmodule
